[hw/rtl/ssp_pkg.sv]
// ssp_pkg: types and constants for the solovay-strassen prime test block
// no dependencies
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int CAUSE_W = 3;
  typedef logic [CAUSE_W-1:0] cause_t;
  localparam cause_t CAUSE_NONE  = 3'd0;
  localparam cause_t CAUSE_EVEN  = 3'd1;
  localparam cause_t CAUSE_ONE   = 3'd2;
  localparam cause_t CAUSE_SMALL = 3'd3;
  localparam cause_t CAUSE_GCD   = 3'd4;
  localparam cause_t CAUSE_JZERO = 3'd5;
  localparam cause_t CAUSE_EULER = 3'd6;

  localparam int PTAB_N = 48;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,    // trial filter, one table prime per step
    ST_DIV,     // shared restoring remainder unit
    ST_GCD,
    ST_JPREP,
    ST_JLOOP,
    ST_PSTEP,   // one modular doubling/add step per cycle
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    DV_FILT,
    DV_GCD,
    DV_JINIT,
    DV_JSWAP,
    DV_PBASE
  } divret_t;

  function automatic logic [7:0] prime_at(input logic [5:0] idx);
    logic [7:0] p;
    case (idx)
      6'd0: p = 8'd3;     6'd1: p = 8'd5;     6'd2: p = 8'd7;     6'd3: p = 8'd11;
      6'd4: p = 8'd13;    6'd5: p = 8'd17;    6'd6: p = 8'd19;    6'd7: p = 8'd23;
      6'd8: p = 8'd29;    6'd9: p = 8'd31;    6'd10: p = 8'd37;   6'd11: p = 8'd41;
      6'd12: p = 8'd43;   6'd13: p = 8'd47;   6'd14: p = 8'd53;   6'd15: p = 8'd59;
      6'd16: p = 8'd61;   6'd17: p = 8'd67;   6'd18: p = 8'd71;   6'd19: p = 8'd73;
      6'd20: p = 8'd79;   6'd21: p = 8'd83;   6'd22: p = 8'd89;   6'd23: p = 8'd97;
      6'd24: p = 8'd101;  6'd25: p = 8'd103;  6'd26: p = 8'd107;  6'd27: p = 8'd109;
      6'd28: p = 8'd113;  6'd29: p = 8'd127;  6'd30: p = 8'd131;  6'd31: p = 8'd137;
      6'd32: p = 8'd139;  6'd33: p = 8'd149;  6'd34: p = 8'd151;  6'd35: p = 8'd157;
      6'd36: p = 8'd163;  6'd37: p = 8'd167;  6'd38: p = 8'd173;  6'd39: p = 8'd179;
      6'd40: p = 8'd181;  6'd41: p = 8'd191;  6'd42: p = 8'd193;  6'd43: p = 8'd197;
      6'd44: p = 8'd199;  6'd45: p = 8'd211;  6'd46: p = 8'd223;  6'd47: p = 8'd227;
      default: p = 8'd227;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/ssp_if.sv]
// ssp_if: valid/ready channel interfaces for request and result
// depends on nothing
`timescale 1ns / 1ps
interface ssp_req_if #(parameter int WIDTH = 64);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] candidate;
  logic [WIDTH-1:0] witness;
  logic             last_witness;
  modport source (output valid, candidate, witness, last_witness, input ready);
  modport sink   (input valid, candidate, witness, last_witness, output ready);
endinterface

interface ssp_res_if;
  logic       valid;
  logic       ready;
  logic       probable_prime;
  logic [2:0] fail_cause;
  modport source (output valid, probable_prime, fail_cause, input ready);
  modport sink   (input valid, probable_prime, fail_cause, output ready);
endinterface

[hw/rtl/solovay_strassen_prime_test_top.sv]
// solovay_strassen_prime_test_top: one witness round per request, iterative
// depends on ssp_pkg and ssp_if
//
// channel | dir | handshake          | payload
// in_     | in  | valid/ready        | candidate, witness, last_witness
// out_    | out | valid/ready        | probable_prime, fail_cause
//
// a request can end early when idle or the filter decides; otherwise its run
// time is set by the one-bit-per-cycle remainder unit and modular-add step unit.
// in_ready is high only in idle; a last-witness result waits in done while the
// output register is still full. synchronous active-low reset clears control.
`timescale 1ns / 1ps
module solovay_strassen_prime_test_top
  import ssp_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int SMALL_PRIME_COUNT = 48
) (
  input logic clk,
  input logic rst_n,
  ssp_req_if.sink   in_req,
  ssp_res_if.source out_res
);

  localparam int BW = $clog2(WIDTH + 1);
  localparam logic [5:0] PLAST = 6'(SMALL_PRIME_COUNT - 1);

  state_t state_r, state_nxt;
  divret_t ret_r;
  logic [WIDTH-1:0] c_r, w_r;
  logic             last_r;
  logic [5:0]       pidx_r;
  logic             pass_r;
  cause_t           cause_r, rcause_r;
  // remainder unit
  logic [WIDTH-1:0] dn_r, dd_r, rem_r;
  logic [BW-1:0]    dcnt_r;
  // gcd / jacobi
  logic [WIDTH-1:0] x_r, m_r;
  logic             jneg_r;
  // power
  logic [WIDTH-1:0] r_r, b_r, e_r, acc_r, mx_r, my_r;
  logic [BW-1:0]    mcnt_r;
  logic             mphase_r;   // 0: r*b, 1: b*b
  logic             madd_r;     // 0: double, 1: add
  logic             res_v_r, res_p_r;
  logic [2:0]       res_c_r;

  logic [WIDTH:0]   rsh;
  logic [WIDTH:0]   asum;
  logic [WIDTH-1:0] amod, aop;
  logic [WIDTH-1:0] cur_p;

  assign cur_p = WIDTH'(prime_at(pidx_r));
  assign rsh   = {rem_r, dn_r[WIDTH-1]};
  assign aop   = madd_r ? mx_r : acc_r;
  assign asum  = {1'b0, acc_r} + {1'b0, aop};
  assign amod  = (asum >= {1'b0, c_r}) ? WIDTH'(asum - {1'b0, c_r}) : asum[WIDTH-1:0];

  assign in_req.ready          = (state_r == ST_IDLE);
  assign out_res.valid         = res_v_r;
  assign out_res.probable_prime = res_p_r;
  assign out_res.fail_cause    = res_c_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          if (!in_req.candidate[0] || in_req.candidate == WIDTH'(1)) state_nxt = ST_DONE;
          else state_nxt = ST_FILT;
        end
      end
      ST_FILT: state_nxt = (c_r == cur_p) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (dcnt_r == '0) begin
          case (ret_r)
            DV_FILT: begin
              if (rem_r == '0) state_nxt = ST_DONE;
              else if (pidx_r == PLAST) state_nxt = ST_GCD;
              else state_nxt = ST_FILT;
            end
            DV_GCD:   state_nxt = ST_GCD;
            DV_JINIT: state_nxt = ST_JLOOP;
            DV_JSWAP: state_nxt = ST_JLOOP;
            default:  state_nxt = ST_PSTEP;
          endcase
        end
      end
      ST_GCD: begin
        if (m_r == '0 && x_r != WIDTH'(1)) state_nxt = ST_DONE;
        else state_nxt = ST_DIV;
      end
      ST_JLOOP: begin
        if (x_r == '0) state_nxt = (m_r != WIDTH'(1)) ? ST_DONE : ST_DIV;
        else if (x_r[0]) state_nxt = ST_DIV;
      end
      ST_PSTEP: begin
        if (mcnt_r == '0 && !madd_r && !mphase_r && e_r == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!last_r || !res_v_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pass_r   <= 1'b1;
      cause_r  <= CAUSE_NONE;
      res_v_r  <= 1'b0;
      madd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_res.valid && out_res.ready) res_v_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_req.valid) begin
            c_r      <= in_req.candidate;
            w_r      <= in_req.witness;
            last_r   <= in_req.last_witness;
            pidx_r   <= 6'd0;
            rcause_r <= CAUSE_NONE;
            if (!in_req.candidate[0]) begin
              rcause_r <= (in_req.candidate == WIDTH'(2)) ? CAUSE_NONE : CAUSE_EVEN;
            end else if (in_req.candidate == WIDTH'(1)) begin
              rcause_r <= CAUSE_ONE;
            end
          end
        end
        ST_FILT: begin
          // equal to a table prime: done, verdict stays clean
          if (c_r != cur_p) begin
            dn_r <= c_r; dd_r <= cur_p; rem_r <= '0; dcnt_r <= BW'(WIDTH);
            ret_r <= DV_FILT;
          end
        end
        ST_DIV: begin
          if (dcnt_r == '0) begin
            case (ret_r)
              DV_FILT: begin
                if (rem_r == '0) begin
                  rcause_r <= CAUSE_SMALL;
                end else if (pidx_r == PLAST) begin
                  // gcd(w, c): start with x=c, y=w
                  x_r <= c_r; m_r <= w_r;
                end else begin
                  pidx_r <= pidx_r + 6'd1;
                end
              end
              DV_GCD: begin
                x_r <= m_r; m_r <= rem_r;
              end
              DV_JINIT: begin
                x_r <= rem_r; m_r <= c_r; jneg_r <= 1'b0;
              end
              DV_JSWAP: begin
                x_r <= rem_r;
              end
              default: begin  // DV_PBASE
                b_r <= rem_r; r_r <= WIDTH'(1);
                e_r <= (c_r - WIDTH'(1)) >> 1;
                mcnt_r <= '0; mphase_r <= 1'b0;
              end
            endcase
          end else begin
            dcnt_r <= dcnt_r - BW'(1);
            dn_r   <= dn_r << 1;
            rem_r  <= (rsh >= {1'b0, dd_r}) ? WIDTH'(rsh - {1'b0, dd_r}) : rsh[WIDTH-1:0];
          end
        end
        ST_GCD: begin
          if (m_r == '0) begin
            if (x_r != WIDTH'(1)) begin
              rcause_r <= CAUSE_GCD;
            end else begin
              dn_r <= w_r; dd_r <= c_r; rem_r <= '0; dcnt_r <= BW'(WIDTH);
              ret_r <= DV_JINIT;
            end
          end else begin
            dn_r <= x_r; dd_r <= m_r; rem_r <= '0; dcnt_r <= BW'(WIDTH);
            ret_r <= DV_GCD;
          end
        end
        ST_JLOOP: begin
          if (x_r == '0) begin
            if (m_r != WIDTH'(1)) begin
              rcause_r <= CAUSE_JZERO;
            end else begin
              dn_r <= w_r; dd_r <= c_r; rem_r <= '0; dcnt_r <= BW'(WIDTH);
              ret_r <= DV_PBASE;
            end
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
            if (m_r[2:0] == 3'd3 || m_r[2:0] == 3'd5) jneg_r <= ~jneg_r;
          end else begin
            // swap, then x := m mod x
            m_r <= x_r;
            if (x_r[1:0] == 2'd3 && m_r[1:0] == 2'd3) jneg_r <= ~jneg_r;
            dn_r <= m_r; dd_r <= x_r; rem_r <= '0; dcnt_r <= BW'(WIDTH);
            ret_r <= DV_JSWAP;
          end
        end
        ST_PSTEP: begin
          if (mcnt_r == '0 && !madd_r) begin
            // start a multiply or finish
            if (!mphase_r && e_r == '0) begin
              if (r_r != (jneg_r ? c_r - WIDTH'(1) : WIDTH'(1))) rcause_r <= CAUSE_EULER;
            end else if (!mphase_r && !e_r[0]) begin
              mphase_r <= 1'b1;
              mx_r <= b_r; my_r <= b_r; acc_r <= '0; mcnt_r <= BW'(WIDTH);
            end else begin
              mx_r <= mphase_r ? b_r : r_r; my_r <= b_r; acc_r <= '0;
              mcnt_r <= BW'(WIDTH);
            end
          end else if (madd_r) begin
            acc_r  <= amod; madd_r <= 1'b0;
            if (mcnt_r == '0) begin
              if (mphase_r) begin
                b_r <= amod; e_r <= e_r >> 1; mphase_r <= 1'b0;
              end else begin
                r_r <= amod; mphase_r <= 1'b1;
              end
            end
          end else begin
            acc_r  <= amod;
            mcnt_r <= mcnt_r - BW'(1);
            my_r   <= my_r << 1;
            if (my_r[WIDTH-1]) begin
              madd_r <= 1'b1;
            end else if (mcnt_r == BW'(1)) begin
              if (mphase_r) begin
                b_r <= amod; e_r <= e_r >> 1; mphase_r <= 1'b0;
              end else begin
                r_r <= amod; mphase_r <= 1'b1;
              end
            end
          end
        end
        ST_DONE: begin
          if (last_r) begin
            // wait until the output register is free
            if (!res_v_r) begin
              res_v_r <= 1'b1;
              res_p_r <= pass_r && (rcause_r == CAUSE_NONE);
              res_c_r <= pass_r ? rcause_r : cause_r;
              pass_r  <= 1'b1;
              cause_r <= CAUSE_NONE;
            end
          end else if (pass_r && rcause_r != CAUSE_NONE) begin
            pass_r  <= 1'b0;
            cause_r <= rcause_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
